// ----- rtl/core/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtg_pkg
// shared constants, types and functions of the mersenne twister generator
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned MT_N = 624;
  localparam int unsigned MAX_KEY_WORDS_DEF = 64;

  localparam logic [9:0] N_LAST  = 10'd623;
  localparam logic [9:0] N_FULL  = 10'd624;
  localparam logic [9:0] M_OFS   = 10'd397;
  localparam logic [9:0] NM_OFS  = 10'd227;

  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] TOP_BIT    = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] LIN_MULT   = 32'd1812433253;
  localparam logic [31:0] KEY_INIT   = 32'd19650218;
  localparam logic [31:0] KEY_MULT   = 32'd1664525;
  localparam logic [31:0] MIX_MULT   = 32'd1566083941;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  localparam logic [2:0] ACT_SEED_WORD = 3'd0;
  localparam logic [2:0] ACT_KEY_WORD  = 3'd1;
  localparam logic [2:0] ACT_SEED_KEY  = 3'd2;
  localparam logic [2:0] ACT_DRAW_WORD = 3'd3;
  localparam logic [2:0] ACT_DRAW_IDX  = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY_KEY  = 2'd1;
  localparam logic [1:0] ST_ZERO_BOUND = 2'd2;
  localparam logic [1:0] ST_NOT_SEEDED = 2'd3;

  typedef struct packed {
    logic        we;
    logic [9:0]  waddr;
    logic [31:0] wdata;
    logic [9:0]  raddr_a;
    logic [9:0]  raddr_b;
  } tw_req_t;

  typedef struct packed {
    logic        we;
    logic [9:0]  waddr;
    logic [31:0] wdata;
    logic [9:0]  raddr;
  } key_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [4:0] clz32(input logic [31:0] x);
    logic [4:0] r;
    r = 5'd31;
    for (int b = 0; b < 32; b++) begin
      if (x[b]) r = 5'(31 - b);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mtg_twister_ram.sv -----
// ----------------------------------------------------------------------------
// mtg_twister_ram
// 624 word state store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mtg_twister_ram (
  input  logic             clk_i,
  input  mtg_pkg::tw_req_t req_i,
  output logic [31:0]      rd_a_o,
  output logic [31:0]      rd_b_o
);

  logic [31:0] mem [mtg_pkg::MT_N];
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem[req_i.raddr_a];
    rd_b_q <= mem[req_i.raddr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- rtl/core/mtg_key_ram.sv -----
// ----------------------------------------------------------------------------
// mtg_key_ram
// key word store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mtg_key_ram #(
  parameter int unsigned MAX_KEY_WORDS = mtg_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic              clk_i,
  input  mtg_pkg::key_req_t req_i,
  output logic [31:0]       rd_o
);

  localparam int unsigned KAW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

  logic [31:0] mem [MAX_KEY_WORDS];
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[KAW-1:0]] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr[KAW-1:0]];
  end

  assign rd_o = rd_q;

endmodule

// ----- rtl/core/mtg_seq.sv -----
// ----------------------------------------------------------------------------
// mtg_seq
// operation sequencer: seeding loops, lazy twist and tempering of draws
// ----------------------------------------------------------------------------
module mtg_seq #(
  parameter int unsigned MAX_KEY_WORDS = mtg_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        action_i,
  input  logic [31:0]       seed_word_i,
  input  logic [5:0]        key_index_i,
  input  logic [31:0]       key_word_i,
  input  logic [6:0]        key_count_i,
  input  logic [31:0]       bound_i,
  output mtg_pkg::res_t     res_o,
  input  logic              res_take_i,
  output mtg_pkg::tw_req_t  tw_o,
  input  logic [31:0]       tw_rd_a_i,
  input  logic [31:0]       tw_rd_b_i,
  output mtg_pkg::key_req_t key_o,
  input  logic [31:0]       key_rd_i
);

  localparam logic [10:0] MAXW = 11'(MAX_KEY_WORDS);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_LIN_MUL = 11'b000_0000_0010,
    S_LIN_WR  = 11'b000_0000_0100,
    S_KEY_RD  = 11'b000_0000_1000,
    S_KEY_WR  = 11'b000_0001_0000,
    S_MIX_RD  = 11'b000_0010_0000,
    S_MIX_WR  = 11'b000_0100_0000,
    S_FIX0    = 11'b000_1000_0000,
    S_DRW_RD  = 11'b001_0000_0000,
    S_DRW_NB  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [9:0]  pos_q, pos_d;
  logic        seeded_q, seeded_d;
  logic        key_mode_q, key_mode_d;
  logic [9:0]  n_q, n_d;
  logic [9:0]  k_q, k_d;
  logic [6:0]  j_q, j_d;
  logic [6:0]  len_q, len_d;
  logic [31:0] p_q, p_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] a_q, a_d;
  logic [31:0] far_q, far_d;
  logic [31:0] bound_q, bound_d;
  logic [4:0]  sh_q, sh_d;
  logic        idx_q, idx_d;
  logic [31:0] val_q, val_d;
  logic [1:0]  stat_q, stat_d;
  logic        drw_wr_q, drw_wr_d;

  logic        accept;
  logic [31:0] p_mix;
  logic [9:0]  cur;
  logic [9:0]  far_addr;
  logic [9:0]  nxt_addr;
  logic [31:0] y_tw;
  logic [31:0] new_word;
  logic [31:0] tempered;
  logic [31:0] cand;
  logic [31:0] w_lin;
  logic [31:0] w_key;
  logic [31:0] w_mix;
  logic [6:0]  j_inc;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign p_mix    = p_q ^ (p_q >> 30);
  assign cur      = (pos_q >= mtg_pkg::N_FULL) ? 10'd0 : pos_q;
  assign far_addr = (cur < mtg_pkg::NM_OFS) ? (cur + mtg_pkg::M_OFS) : (cur - mtg_pkg::NM_OFS);
  assign nxt_addr = (pos_q == mtg_pkg::N_LAST) ? 10'd0 : (pos_q + 10'd1);
  assign y_tw     = (a_q & mtg_pkg::TOP_BIT) | (tw_rd_a_i & mtg_pkg::LOW_BITS);
  assign new_word = far_q ^ (y_tw >> 1) ^ (y_tw[0] ? mtg_pkg::TWIST_XOR : 32'd0);
  assign tempered = mtg_pkg::temper(new_word);
  assign cand     = tempered >> sh_q;
  assign w_lin    = prod_q + {22'd0, n_q};
  assign w_key    = (tw_rd_a_i ^ prod_q) + key_rd_i + {25'd0, j_q};
  assign w_mix    = (tw_rd_a_i ^ prod_q) - {22'd0, n_q};
  assign j_inc    = j_q + 7'd1;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    seeded_d   = seeded_q;
    key_mode_d = key_mode_q;
    n_d        = n_q;
    k_d        = k_q;
    j_d        = j_q;
    len_d      = len_q;
    p_d        = p_q;
    prod_d     = prod_q;
    a_d        = a_q;
    far_d      = far_q;
    bound_d    = bound_q;
    sh_d       = sh_q;
    idx_d      = idx_q;
    val_d      = val_q;
    stat_d     = stat_q;
    drw_wr_d   = 1'b0;
    tw_o       = '0;
    key_o      = '0;
    key_o.raddr = {3'd0, j_q};

    if (drw_wr_q) begin
      // write-back of the twisted word and tempering
      tw_o.we    = 1'b1;
      tw_o.waddr = pos_q;
      tw_o.wdata = new_word;
      pos_d      = pos_q + 10'd1;
      if (idx_q && (cand >= bound_q)) begin
        state_d = S_DRW_RD;
      end else begin
        val_d   = idx_q ? cand : tempered;
        stat_d  = mtg_pkg::ST_OK;
        state_d = S_DONE;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d   = '0;
          stat_d  = mtg_pkg::ST_OK;
          state_d = S_DONE;
          case (action_i)
            mtg_pkg::ACT_SEED_WORD: begin
              tw_o.we    = 1'b1;
              tw_o.waddr = '0;
              tw_o.wdata = seed_word_i;
              p_d        = seed_word_i;
              n_d        = 10'd1;
              key_mode_d = 1'b0;
              state_d    = S_LIN_MUL;
            end
            mtg_pkg::ACT_KEY_WORD: begin
              key_o.we    = ({5'd0, key_index_i} < MAXW);
              key_o.waddr = {4'd0, key_index_i};
              key_o.wdata = key_word_i;
            end
            mtg_pkg::ACT_SEED_KEY: begin
              if (key_count_i == 7'd0) begin
                stat_d = mtg_pkg::ST_EMPTY_KEY;
              end else begin
                tw_o.we    = 1'b1;
                tw_o.waddr = '0;
                tw_o.wdata = mtg_pkg::KEY_INIT;
                p_d        = mtg_pkg::KEY_INIT;
                n_d        = 10'd1;
                key_mode_d = 1'b1;
                len_d      = ({4'd0, key_count_i} > MAXW) ? MAXW[6:0] : key_count_i;
                state_d    = S_LIN_MUL;
              end
            end
            mtg_pkg::ACT_DRAW_WORD: begin
              if (!seeded_q) begin
                stat_d = mtg_pkg::ST_NOT_SEEDED;
              end else begin
                idx_d   = 1'b0;
                state_d = S_DRW_RD;
              end
            end
            mtg_pkg::ACT_DRAW_IDX: begin
              if (bound_i == 32'd0) begin
                stat_d = mtg_pkg::ST_ZERO_BOUND;
              end else if (!seeded_q) begin
                stat_d = mtg_pkg::ST_NOT_SEEDED;
              end else begin
                idx_d   = 1'b1;
                bound_d = bound_i;
                sh_d    = mtg_pkg::clz32(bound_i);
                state_d = S_DRW_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIN_MUL: begin
        prod_d  = mtg_pkg::LIN_MULT * p_mix;
        state_d = S_LIN_WR;
      end
      S_LIN_WR: begin
        tw_o.we    = 1'b1;
        tw_o.waddr = n_q;
        tw_o.wdata = w_lin;
        p_d        = w_lin;
        n_d        = n_q + 10'd1;
        state_d    = S_LIN_MUL;
        if (n_q == mtg_pkg::N_LAST) begin
          pos_d    = mtg_pkg::N_FULL;
          seeded_d = 1'b1;
          if (key_mode_q) begin
            p_d     = mtg_pkg::KEY_INIT;
            n_d     = 10'd1;
            k_d     = mtg_pkg::N_FULL;
            j_d     = '0;
            state_d = S_KEY_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_KEY_RD: begin
        tw_o.raddr_a = n_q;
        prod_d       = p_mix * mtg_pkg::KEY_MULT;
        state_d      = S_KEY_WR;
      end
      S_KEY_WR: begin
        tw_o.we    = 1'b1;
        tw_o.waddr = n_q;
        tw_o.wdata = w_key;
        p_d        = w_key;
        n_d        = (n_q == mtg_pkg::N_LAST) ? 10'd1 : (n_q + 10'd1);
        j_d        = (j_inc >= len_q) ? 7'd0 : j_inc;
        if (k_q == 10'd1) begin
          k_d     = mtg_pkg::N_LAST;
          state_d = S_MIX_RD;
        end else begin
          k_d     = k_q - 10'd1;
          state_d = S_KEY_RD;
        end
      end
      S_MIX_RD: begin
        tw_o.raddr_a = n_q;
        prod_d       = p_mix * mtg_pkg::MIX_MULT;
        state_d      = S_MIX_WR;
      end
      S_MIX_WR: begin
        tw_o.we    = 1'b1;
        tw_o.waddr = n_q;
        tw_o.wdata = w_mix;
        p_d        = w_mix;
        n_d        = (n_q == mtg_pkg::N_LAST) ? 10'd1 : (n_q + 10'd1);
        k_d        = k_q - 10'd1;
        state_d    = (k_q == 10'd1) ? S_FIX0 : S_MIX_RD;
      end
      S_FIX0: begin
        tw_o.we    = 1'b1;
        tw_o.waddr = '0;
        tw_o.wdata = mtg_pkg::TOP_BIT;
        pos_d      = mtg_pkg::N_FULL;
        state_d    = S_DONE;
      end
      S_DRW_RD: begin
        if (!drw_wr_q) begin
          tw_o.raddr_a = cur;
          tw_o.raddr_b = far_addr;
          pos_d        = cur;
          state_d      = S_DRW_NB;
        end
      end
      S_DRW_NB: begin
        if (!drw_wr_q) begin
          tw_o.raddr_a = nxt_addr;
          a_d          = tw_rd_a_i;
          far_d        = tw_rd_b_i;
          drw_wr_d     = 1'b1;
        end
      end
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= mtg_pkg::N_FULL;
      seeded_q <= 1'b0;
      drw_wr_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      seeded_q <= seeded_d;
      drw_wr_q <= drw_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_mode_q <= key_mode_d;
    n_q        <= n_d;
    k_q        <= k_d;
    j_q        <= j_d;
    len_q      <= len_d;
    p_q        <= p_d;
    prod_q     <= prod_d;
    a_q        <= a_d;
    far_q      <= far_d;
    bound_q    <= bound_d;
    sh_q       <= sh_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    stat_q     <= stat_d;
  end

  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.value  = val_q;
  assign res_o.status = stat_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mtg_pkg::N_FULL) else $error("draw position beyond store");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_draw_unseeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !seeded_q && (action_i == mtg_pkg::ACT_DRAW_WORD) |=> state_q == S_DONE)
    else $error("unseeded draw started work");

  a_loop_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KEY_WR || state_q == S_MIX_WR) |-> n_q != 10'd0)
    else $error("seeding loop touched word zero");

endmodule

// ----- rtl/core/mt19937_generator.sv -----
// ----------------------------------------------------------------------------
// mt19937_generator
// 32-bit mersenne twister with word and key seeding and bounded index draws
// ----------------------------------------------------------------------------
// usage: one input transaction (in_valid_i high, in_stall_o low) carries an
// action; every transaction gives exactly one output transaction with value
// and status. in_stall_o is high while an action is being worked on.
// work per action:
//   draw word: the word is twisted on the fly from three state reads
//   draw index: a rejected draw is retried with the next twisted word
//   seed word: multiplier bound
//   seed from key: three passes over the 624 word store
// rate is set by the single write port of the state store and the shared
// multiplier. a finished result sits in the output register, the next action
// is taken once the result has moved there.
// reset: unseeded, draw position at the end of the store, no result pending;
// the state and key stores keep their contents. a stalled output holds its
// value and status until taken.
// ----------------------------------------------------------------------------
module mt19937_generator #(
  parameter int unsigned MAX_KEY_WORDS = mtg_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] seed_word_i,
  input  logic [5:0]  key_index_i,
  input  logic [31:0] key_word_i,
  input  logic [6:0]  key_count_i,
  input  logic [31:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);

  mtg_pkg::res_t     res;
  mtg_pkg::tw_req_t  tw_req;
  mtg_pkg::key_req_t key_req;
  logic [31:0]       tw_rd_a;
  logic [31:0]       tw_rd_b;
  logic [31:0]       key_rd;
  logic              take;

  logic        out_valid_q;
  logic [31:0] value_q;
  logic [1:0]  status_q;

  assign take = res.valid && (!out_valid_q || !out_stall_i);

  mtg_seq #(
    .MAX_KEY_WORDS(MAX_KEY_WORDS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .seed_word_i(seed_word_i),
    .key_index_i(key_index_i),
    .key_word_i (key_word_i),
    .key_count_i(key_count_i),
    .bound_i    (bound_i),
    .res_o      (res),
    .res_take_i (take),
    .tw_o       (tw_req),
    .tw_rd_a_i  (tw_rd_a),
    .tw_rd_b_i  (tw_rd_b),
    .key_o      (key_req),
    .key_rd_i   (key_rd)
  );

  mtg_twister_ram u_twister_ram (
    .clk_i (clk_i),
    .req_i (tw_req),
    .rd_a_o(tw_rd_a),
    .rd_b_o(tw_rd_b)
  );

  mtg_key_ram #(
    .MAX_KEY_WORDS(MAX_KEY_WORDS)
  ) u_key_ram (
    .clk_i(clk_i),
    .req_i(key_req),
    .rd_o (key_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q  <= res.value;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule
